/* rtl/m3i_pkg.sv */
`timescale 1ns / 1ps

package m3i_pkg;

	// element format
	localparam int EW = 32;
	localparam int FB = 16;

	// product, cofactor and determinant widths (signed)
	localparam int PW = 2 * EW;
	localparam int CW = 2 * EW + 1;
	localparam int HW = CW - EW;
	localparam int DW = 3 * EW + 3;

	// divider operand widths (unsigned)
	localparam int NW0 = CW + 2 * FB + 1;
	localparam int NW = ((NW0 > DW) ? NW0 : DW) + 1;
	localparam int VW = DW + 1;
	localparam int XW = (VW + EW > NW) ? VW + EW : NW;

	// one compare stage plus one stage per quotient bit
	localparam int DIV_LAT = EW + 1;

	typedef struct packed {
		logic signed [EW-1:0] m00;
		logic signed [EW-1:0] m01;
		logic signed [EW-1:0] m02;
		logic signed [EW-1:0] m10;
		logic signed [EW-1:0] m11;
		logic signed [EW-1:0] m12;
		logic signed [EW-1:0] m20;
		logic signed [EW-1:0] m21;
		logic signed [EW-1:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [EW-1:0] inv00;
		logic signed [EW-1:0] inv01;
		logic signed [EW-1:0] inv02;
		logic signed [EW-1:0] inv10;
		logic signed [EW-1:0] inv11;
		logic signed [EW-1:0] inv12;
		logic signed [EW-1:0] inv20;
		logic signed [EW-1:0] inv21;
		logic signed [EW-1:0] inv22;
		logic singular;
		logic saturated;
	} inv_t;

	typedef struct packed {
		logic       valid;
		logic       singular;
		logic [8:0] neg;
	} side_t;

endpackage

/* rtl/m3i_div.sv */
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
module m3i_div import m3i_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [VW-1:0] den,
	output logic [EW-1:0] quo,
	output logic          big
);

	logic [NW-1:0] rem_s [DIV_LAT];
	logic [VW-1:0] den_s [DIV_LAT];
	logic [EW-1:0] quo_s [DIV_LAT];
	logic          big_s [DIV_LAT];
	logic [NW-1:0] rem_nx [DIV_LAT];
	logic [EW-1:0] quo_nx [DIV_LAT];
	logic          big0;

	always_comb begin
		logic [XW-1:0] rx;
		logic [XW-1:0] dx;
		rx = '0;
		dx = '0;
		rem_nx[0] = num;
		quo_nx[0] = '0;
		// quotient at or above 2^EW: flag it
		big0 = XW'(num) >= (XW'(den) << EW);
		for (int j = 1; j < DIV_LAT; j++) begin
			rx = XW'(rem_s[j-1]);
			dx = XW'(den_s[j-1]) << (EW - j);
			if (rx >= dx) begin
				rem_nx[j] = NW'(rx - dx);
				quo_nx[j] = quo_s[j-1] | (EW'(1) << (EW - j));
			end else begin
				rem_nx[j] = rem_s[j-1];
				quo_nx[j] = quo_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_nx;
			quo_s <= quo_nx;
			den_s[0] <= den;
			big_s[0] <= big0;
			for (int j = 1; j < DIV_LAT; j++) begin
				den_s[j] <= den_s[j-1];
				big_s[j] <= big_s[j-1];
			end
		end
	end

	assign quo = quo_s[DIV_LAT-1];
	assign big = big_s[DIV_LAT-1];

endmodule

/* rtl/matrix3_inverse.sv */
`timescale 1ns / 1ps

// 3x3 matrix inverse, signed fixed point (EW bits, FB fraction bits).
// Input channel: mat_valid / mat_stall carry one word, the matrix in row-major
// order. Output channel: inv_valid / inv_stall carry one word, the inverse in
// row-major order plus the singular and saturated flags.
// A word moves when valid is high and stall is low at a rising clk edge.
// Throughput: one matrix per cycle unless inv_stall holds the output. From
// acceptance to inv_valid: 7 arithmetic stages, an EW+1 stage divider, one
// output register; the divider, one quotient bit per stage, is most of that depth.
// Every element is the exact quotient adj/det, rounded to nearest with ties
// away from zero, then clamped to range (saturated set). A zero determinant
// gives all-zero elements with singular set.
// The whole pipeline advances together: when the output word is held by
// inv_stall, mat_stall rises and every stage holds, so nothing is lost.
// arst_n clears all valid bits; no word is in flight after reset.
module matrix3_inverse import m3i_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic mat_valid,
	output logic mat_stall,
	input  mat_t mat,
	output logic inv_valid,
	input  logic inv_stall,
	output inv_t inv
);

	// operand pairs of the cofactor products: cof[k] = p[2k] - p[2k+1]
	localparam int PA [18] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2, 1, 0, 1, 2, 2, 0, 0, 1};
	localparam int PB [18] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6, 6, 7, 5, 4, 3, 5, 4, 3};

	logic en;
	logic signed [EW-1:0] m [9];

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [PW-1:0]   prod_s1 [18];
	logic signed [EW-1:0]   row_s1 [3];
	logic signed [CW-1:0]   cof_s2 [9];
	logic signed [EW-1:0]   row_s2 [3];
	logic signed [2*EW+1:0] plo_s3 [3];
	logic signed [2*EW:0]   phi_s3 [3];
	logic signed [CW-1:0]   cof_s3 [9];
	logic signed [DW-1:0]   dp_s4 [3];
	logic signed [CW-1:0]   cof_s4 [9];
	logic signed [DW-1:0]   det_s5;
	logic signed [CW-1:0]   cof_s5 [9];
	logic [DW-1:0]          dabs_s6;
	logic                   dneg_s6, dz_s6;
	logic [CW-1:0]          cabs_s6 [9];
	logic [8:0]             cneg_s6;
	logic [NW-1:0]          num_s7 [9];
	logic [VW-1:0]          den_s7;
	logic [8:0]             neg_s7;
	logic                   dz_s7;
	side_t                  side_s [DIV_LAT];

	logic [EW-1:0]          quo [9];
	logic [8:0]             big;
	logic signed [EW-1:0]   elem [9];
	logic                   sat_any;
	inv_t                   inv_nx;
	logic                   inv_valid_q;
	inv_t                   inv_q;

	// advance everything unless a finished word is held
	assign en = !inv_valid_q || !inv_stall;
	assign mat_stall = !en;

	assign m[0] = mat.m00;
	assign m[1] = mat.m01;
	assign m[2] = mat.m02;
	assign m[3] = mat.m10;
	assign m[4] = mat.m11;
	assign m[5] = mat.m12;
	assign m[6] = mat.m20;
	assign m[7] = mat.m21;
	assign m[8] = mat.m22;

	// valid bits travel with the data; flags ride alongside the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) side_s[i] <= '0;
			inv_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= mat_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			side_s[0].valid <= vld_s7;
			side_s[0].singular <= dz_s7;
			side_s[0].neg <= neg_s7;
			for (int i = 1; i < DIV_LAT; i++) side_s[i] <= side_s[i-1];
			inv_valid_q <= side_s[DIV_LAT-1].valid;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: the eighteen element products
			for (int i = 0; i < 18; i++) prod_s1[i] <= PW'(m[PA[i]]) * PW'(m[PB[i]]);
			for (int i = 0; i < 3; i++) row_s1[i] <= m[i];

			// s2: cofactors
			for (int k = 0; k < 9; k++)
				cof_s2[k] <= CW'(prod_s1[2*k]) - CW'(prod_s1[2*k+1]);
			row_s2 <= row_s1;

			// s3: first row times its cofactors, split into low and high halves
			for (int k = 0; k < 3; k++) begin
				plo_s3[k] <= (2*EW+2)'(row_s2[k]) *
					(2*EW+2)'($signed({1'b0, cof_s2[k][EW-1:0]}));
				phi_s3[k] <= (2*EW+1)'(row_s2[k]) * (2*EW+1)'($signed(cof_s2[k][CW-1:EW]));
			end
			cof_s3 <= cof_s2;

			// s4: join the halves
			for (int k = 0; k < 3; k++)
				dp_s4[k] <= (DW'(phi_s3[k]) <<< EW) + DW'(plo_s3[k]);
			cof_s4 <= cof_s3;

			// s5: determinant
			det_s5 <= dp_s4[0] + dp_s4[1] + dp_s4[2];
			cof_s5 <= cof_s4;

			// s6: magnitudes and signs
			dneg_s6 <= det_s5[DW-1];
			dz_s6 <= (det_s5 == '0);
			dabs_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			for (int k = 0; k < 9; k++) begin
				cneg_s6[k] <= cof_s5[k][CW-1];
				cabs_s6[k] <= cof_s5[k][CW-1] ? CW'(-cof_s5[k]) : CW'(cof_s5[k]);
			end

			// s7: rounding dividend 2|C|*2^(2FB) + |D| over divisor 2|D|
			for (int k = 0; k < 9; k++) begin
				num_s7[k] <= (NW'(cabs_s6[k]) << (2*FB + 1)) + NW'(dabs_s6);
				neg_s7[k] <= cneg_s6[k] ^ dneg_s6;
			end
			den_s7 <= {dabs_s6, 1'b0};
			dz_s7 <= dz_s6;

			inv_q <= inv_nx;
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_div
		m3i_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s7[k]),
			.den (den_s7),
			.quo (quo[k]),
			.big (big[k])
		);
	end

	// clamp one quotient to range; returns {saturated, value}
	function automatic logic [EW:0] clamp_q(logic [EW-1:0] q, logic ovf, logic neg);
		logic [EW-1:0] maxp;
		logic [EW-1:0] minn;
		logic          sat;
		logic [EW-1:0] val;
		maxp = {1'b0, {(EW-1){1'b1}}};
		minn = {1'b1, {(EW-1){1'b0}}};
		if (neg) begin
			sat = ovf || (q > minn);
			val = sat ? minn : EW'(EW'(0) - q);
		end else begin
			sat = ovf || q[EW-1];
			val = sat ? maxp : q;
		end
		return {sat, val};
	endfunction

	// lane k holds cofactor k; adjugate element (r,c) is cofactor (c,r)
	always_comb begin
		logic [EW:0] cq;
		cq = '0;
		sat_any = 1'b0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				cq = clamp_q(quo[c*3+r], big[c*3+r], side_s[DIV_LAT-1].neg[c*3+r]);
				elem[r*3+c] = side_s[DIV_LAT-1].singular ? '0 : $signed(cq[EW-1:0]);
				sat_any = sat_any | (cq[EW] & !side_s[DIV_LAT-1].singular);
			end
		end
		inv_nx.inv00 = elem[0];
		inv_nx.inv01 = elem[1];
		inv_nx.inv02 = elem[2];
		inv_nx.inv10 = elem[3];
		inv_nx.inv11 = elem[4];
		inv_nx.inv12 = elem[5];
		inv_nx.inv20 = elem[6];
		inv_nx.inv21 = elem[7];
		inv_nx.inv22 = elem[8];
		inv_nx.singular = side_s[DIV_LAT-1].singular;
		inv_nx.saturated = sat_any;
	end

	assign inv_valid = inv_valid_q;
	assign inv = inv_q;

endmodule

/* tb/matrix3_inverse_tb.sv */
`timescale 1ns / 1ps

module matrix3_inverse_tb;
	import m3i_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;

	// wide enough for |cofactor| << 2F+1, plus the determinant
	typedef logic signed [191:0] wide_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic mat_stall;
	mat_t mat = '0;
	logic inv_valid;
	logic inv_stall = 1'b0;
	inv_t inv;

	inv_t expected_inverses[$];
	int error_count = 0;
	int cycle_count = 0;

	matrix3_inverse u_top (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
		.inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: exact cofactors and determinant, one rounded division
	// per adjugate entry, then clamp to the element range.
	// ------------------------------------------------------------------
	function automatic logic [EW-1:0] round_quotient(wide_t cof, wide_t det, ref logic sat);
		logic neg;
		logic [191:0] num, den, q;
		logic [191:0] lim;
		neg = cof[191] ^ det[191];
		num = cof[191] ? -cof : cof;
		den = det[191] ? -det : det;
		lim = 192'(1) << (EW - 1);
		// round to nearest, ties away from zero: (2n + d) / 2d
		num = (num << (2 * FB + 1)) + den;
		q = num / (den << 1);
		if (neg) begin
			if (q > lim) begin
				sat = 1'b1;
				q = lim;
			end
			return -q[EW-1:0];
		end
		if (q > lim - 1) begin
			sat = 1'b1;
			q = lim - 1;
		end
		return q[EW-1:0];
	endfunction

	function automatic inv_t invert_matrix(mat_t a);
		wide_t e[9];
		wide_t cof[9];
		wide_t det;
		logic [EW-1:0] r[9];
		logic sat;
		inv_t res;
		e[0] = wide_t'(a.m00); e[1] = wide_t'(a.m01); e[2] = wide_t'(a.m02);
		e[3] = wide_t'(a.m10); e[4] = wide_t'(a.m11); e[5] = wide_t'(a.m12);
		e[6] = wide_t'(a.m20); e[7] = wide_t'(a.m21); e[8] = wide_t'(a.m22);
		cof[0] = e[4] * e[8] - e[5] * e[7];
		cof[1] = e[5] * e[6] - e[3] * e[8];
		cof[2] = e[3] * e[7] - e[4] * e[6];
		cof[3] = e[2] * e[7] - e[1] * e[8];
		cof[4] = e[0] * e[8] - e[2] * e[6];
		cof[5] = e[1] * e[6] - e[0] * e[7];
		cof[6] = e[1] * e[5] - e[2] * e[4];
		cof[7] = e[2] * e[3] - e[0] * e[5];
		cof[8] = e[0] * e[4] - e[1] * e[3];
		det = e[0] * cof[0] + e[1] * cof[1] + e[2] * cof[2];
		res = '0;
		if (det == 0) begin
			res.singular = 1'b1;
			return res;
		end
		sat = 1'b0;
		// adjugate is the transposed cofactor matrix
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				r[i * 3 + j] = round_quotient(cof[j * 3 + i], det, sat);
		res.inv00 = r[0]; res.inv01 = r[1]; res.inv02 = r[2];
		res.inv10 = r[3]; res.inv11 = r[4]; res.inv12 = r[5];
		res.inv20 = r[6]; res.inv21 = r[7]; res.inv22 = r[8];
		res.saturated = sat;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result checking: compare each accepted word with the oldest prediction
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [EW-1:0] exp_v, logic [EW-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		inv_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && inv_valid && !inv_stall) begin
			if (expected_inverses.size() == 0) begin
				$error("inverse word with no matrix pending");
				error_count++;
			end else begin
				want = expected_inverses.pop_front();
				check_field("inv00", want.inv00, inv.inv00);
				check_field("inv01", want.inv01, inv.inv01);
				check_field("inv02", want.inv02, inv.inv02);
				check_field("inv10", want.inv10, inv.inv10);
				check_field("inv11", want.inv11, inv.inv11);
				check_field("inv12", want.inv12, inv.inv12);
				check_field("inv20", want.inv20, inv.inv20);
				check_field("inv21", want.inv21, inv.inv21);
				check_field("inv22", want.inv22, inv.inv22);
				check_field("singular", EW'(want.singular), EW'(inv.singular));
				check_field("saturated", EW'(want.saturated), EW'(inv.saturated));
			end
		end
	end

	// Timeout guard
	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver stall: switch among free-running, random and long-hold
	// modes so stalls land on every pipeline phase.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		static int mode = 0;
		static int mode_left = 0;
		static int hold_left = 0;
		if (mode_left == 0) begin
			mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 300);
		end
		mode_left--;
		case (mode)
			0: inv_stall = 1'b0;
			1: inv_stall = ($urandom_range(0, 1) == 1);
			2: inv_stall = ($urandom_range(0, 7) == 0);
			default: begin
				// long holds with short release windows
				if (hold_left > 0) begin
					hold_left--;
					inv_stall = 1'b1;
				end else begin
					inv_stall = 1'b0;
					if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(5, 60);
				end
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sender: hold the word until accepted, then record its prediction
	// ------------------------------------------------------------------
	int burst_left = 0;

	task automatic send_matrix(mat_t a);
		// gap between bursts
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				@(negedge clk);
				mat_valid = 1'b0;
				repeat ($urandom_range(0, 12)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		mat = a;
		mat_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!mat_stall) break;
		end
		expected_inverses.push_back(invert_matrix(a));
	endtask

	function automatic mat_t make_matrix(logic [EW-1:0] v[9]);
		mat_t a;
		a.m00 = v[0]; a.m01 = v[1]; a.m02 = v[2];
		a.m10 = v[3]; a.m11 = v[4]; a.m12 = v[5];
		a.m20 = v[6]; a.m21 = v[7]; a.m22 = v[8];
		return a;
	endfunction

	function automatic mat_t diag_matrix(logic [EW-1:0] d0, logic [EW-1:0] d1,
			logic [EW-1:0] d2);
		logic [EW-1:0] v[9];
		foreach (v[i]) v[i] = '0;
		v[0] = d0; v[4] = d1; v[8] = d2;
		return make_matrix(v);
	endfunction

	function automatic mat_t fill_matrix(logic [EW-1:0] x);
		logic [EW-1:0] v[9];
		foreach (v[i]) v[i] = x;
		return make_matrix(v);
	endfunction

	// element near unity scale so most inverses stay in range
	function automatic logic [EW-1:0] moderate_elem();
		int signed x;
		x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		return EW'(x);
	endfunction

	function automatic logic [EW-1:0] any_elem();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return EW'($signed($urandom_range(0, 8)) - 4);
			default: return $urandom();
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	localparam logic [EW-1:0] ONE = EW'(1) << FB;
	localparam logic [EW-1:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [EW-1:0] MINV = 32'h8000_0000;

	task automatic test_directed();
		logic [EW-1:0] v[9];
		send_matrix(diag_matrix(ONE, ONE, ONE));
		send_matrix(diag_matrix(ONE << 1, -ONE, ONE << 2));
		send_matrix(diag_matrix(EW'(3) << FB, EW'(3) << FB, EW'(3) << FB));
		// rounding with odd divisors
		send_matrix(diag_matrix(EW'(3), EW'(5), EW'(7)));
		send_matrix(diag_matrix(EW'(1), EW'(1), EW'(1)));          // huge, clamps high
		send_matrix(diag_matrix(-EW'(1), EW'(1), EW'(1)));         // clamps low
		send_matrix(diag_matrix(MAXV, MAXV, MAXV));
		send_matrix(diag_matrix(MINV, MINV, MINV));
		send_matrix(diag_matrix(MINV, MAXV, MINV));
		send_matrix(diag_matrix(ONE << 1, ONE << 1, -(ONE << 1)));
		send_matrix(fill_matrix('0));                             // zero determinant
		send_matrix(fill_matrix(MAXV));
		send_matrix(fill_matrix(MINV));
		send_matrix(fill_matrix(32'hFFFF_FFFF));
		// rank two: third row equals the first
		v = '{ONE, ONE << 1, EW'(3) << FB, EW'(4) << FB, EW'(5) << FB, EW'(6) << FB,
			ONE, ONE << 1, EW'(3) << FB};
		send_matrix(make_matrix(v));
		// general full matrix with mixed signs
		v = '{ONE << 1, -ONE, '0, -ONE, ONE << 1, -ONE, '0, -ONE, ONE << 1};
		send_matrix(make_matrix(v));
		v = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, EW'(0)};
		send_matrix(make_matrix(v));
		v = '{MAXV, MINV, EW'(1), EW'(0), MAXV, MINV, MINV, EW'(1), MAXV};
		send_matrix(make_matrix(v));
		v = '{EW'(1), EW'(2), EW'(3), EW'(0), EW'(1), EW'(4), EW'(5), EW'(6), EW'(0)};
		send_matrix(make_matrix(v));
		v = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
			32'h3333_3333, 32'hCCCC_CCCC, 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678};
		send_matrix(make_matrix(v));
	endtask

	task automatic test_well_conditioned(int count);
		logic [EW-1:0] v[9];
		repeat (count) begin
			foreach (v[i]) v[i] = moderate_elem();
			// boost the diagonal so most matrices invert without clamping
			if ($urandom_range(0, 1) == 1) begin
				v[0] = v[0] + (ONE << 2);
				v[4] = v[4] - (ONE << 2);
				v[8] = v[8] + (ONE << 3);
			end
			send_matrix(make_matrix(v));
		end
	endtask

	task automatic test_full_range(int count);
		logic [EW-1:0] v[9];
		repeat (count) begin
			foreach (v[i]) v[i] = any_elem();
			send_matrix(make_matrix(v));
		end
	endtask

	task automatic test_singular(int count);
		logic [EW-1:0] v[9];
		int src, dst;
		repeat (count) begin
			foreach (v[i]) v[i] = ($urandom_range(0, 1) == 1) ? moderate_elem() : any_elem();
			src = $urandom_range(0, 2);
			dst = (src + $urandom_range(1, 2)) % 3;
			case ($urandom_range(0, 2))
				0: for (int j = 0; j < 3; j++) v[dst * 3 + j] = v[src * 3 + j];
				1: for (int j = 0; j < 3; j++) v[j * 3 + dst] = v[j * 3 + src];
				default: for (int j = 0; j < 3; j++) v[dst * 3 + j] = '0;
			endcase
			send_matrix(make_matrix(v));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_well_conditioned(1000);
		test_full_range(600);
		test_singular(250);

		@(negedge clk);
		mat_valid = 1'b0;
		wait (expected_inverses.size() == 0);
		// any word that shows up now is caught by the checker as unexpected
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/m3i_pkg.sv
rtl/m3i_div.sv
rtl/matrix3_inverse.sv
tb/matrix3_inverse_tb.sv
